// ===== design/body_soil_avalanche_update_assert.svh =====
`ifndef BODY_SOIL_AVALANCHE_UPDATE_ASSERT_SVH
`define BODY_SOIL_AVALANCHE_UPDATE_ASSERT_SVH

// Clocked implication, checked outside reset.
`define BSAU_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Condition that must hold on every clock edge outside reset.
`define BSAU_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error(msg);

`endif

// ===== design/bsau_pkg.sv =====
`default_nettype none

package bsau_pkg;

  localparam int unsigned MAG_W = 34;
  localparam int unsigned NUM_W = 35;
  localparam int unsigned REM_W = 32;
  localparam int unsigned DIV_STAGES = MAG_W;

  localparam logic [3:0] OP_TERRAIN     = 4'd0;
  localparam logic [3:0] OP_S1_SOIL     = 4'd1;
  localparam logic [3:0] OP_S1_BUCKET   = 4'd2;
  localparam logic [3:0] OP_S2O_SOIL    = 4'd3;
  localparam logic [3:0] OP_S2O_BUCKET  = 4'd4;
  localparam logic [3:0] OP_S2_SOIL     = 4'd5;
  localparam logic [3:0] OP_S2_BUCKET   = 4'd6;
  localparam logic [3:0] OP_B1_SOIL     = 4'd7;
  localparam logic [3:0] OP_B1_BUCKET   = 4'd8;

  localparam logic [1:0] CFG_DH   = 2'd0;
  localparam logic [1:0] CFG_TOL  = 2'd1;
  localparam logic [1:0] CFG_CELL = 2'd2;

  localparam logic [1:0] LAYER_FIRST  = 2'd0;
  localparam logic [1:0] LAYER_SECOND = 2'd2;

  typedef struct packed {
    logic [3:0]         operation;
    logic signed [31:0] src_soil_bottom;
    logic signed [31:0] src_soil_top;
    logic signed [31:0] tgt_terrain;
    logic signed [31:0] tgt_bucket1_bottom;
    logic signed [31:0] tgt_bucket1_top;
    logic signed [31:0] tgt_bucket2_bottom;
    logic signed [31:0] tgt_bucket2_top;
    logic signed [31:0] tgt_soil1_top;
    logic signed [31:0] tgt_soil2_top;
    logic [9:0]         target_row;
    logic [9:0]         target_col;
  } bsau_cmd_t;

  typedef struct packed {
    logic signed [31:0] new_src_bottom;
    logic signed [31:0] new_src_top;
    logic signed [31:0] new_terrain;
    logic signed [31:0] new_soil1_bottom;
    logic signed [31:0] new_soil1_top;
    logic signed [31:0] new_soil2_bottom;
    logic signed [31:0] new_soil2_top;
    logic               created_valid;
    logic [1:0]         created_layer;
    logic [9:0]         created_row;
    logic [9:0]         created_col;
  } bsau_res_t;

  typedef struct packed {
    bsau_cmd_t                cmd;
    logic signed [31:0]       base;
    logic signed [NUM_W-1:0]  num;
  } bsau_work_t;

  function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
    logic signed [35:0] hi;
    logic signed [35:0] lo;
    hi = 36'sd2147483647;
    lo = -36'sd2147483648;
    if (v > hi) begin
      sat32 = 32'sh7FFFFFFF;
    end else if (v < lo) begin
      sat32 = 32'sh80000000;
    end else begin
      sat32 = v[31:0];
    end
  endfunction

endpackage

`default_nettype wire

// ===== design/bsau_prep.sv =====
`default_nettype none

module bsau_prep (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     valid_i,
  input  wire bsau_pkg::bsau_cmd_t      cmd_i,
  input  wire logic [30:0]              dh_i,
  input  wire logic [15:0]              tol_i,
  output logic                          valid_o,
  output bsau_pkg::bsau_work_t          work_o,
  output logic [bsau_pkg::MAG_W-1:0]    mag_o
);
  import bsau_pkg::*;

  logic                    valid_q;
  bsau_work_t              work_d, work_q;
  logic [MAG_W-1:0]        mag_d, mag_q;
  logic signed [31:0]      base;
  logic signed [NUM_W-1:0] num;

  always_comb begin
    case (cmd_i.operation)
      OP_TERRAIN:                base = cmd_i.tgt_terrain;
      OP_S1_SOIL, OP_B1_SOIL:    base = cmd_i.tgt_soil1_top;
      OP_S1_BUCKET, OP_B1_BUCKET: base = cmd_i.tgt_bucket1_top;
      OP_S2O_SOIL, OP_S2_SOIL:   base = cmd_i.tgt_soil2_top;
      default:                   base = cmd_i.tgt_bucket2_top;
    endcase
    num = $signed({4'b0, dh_i}) + NUM_W'(cmd_i.src_soil_top) + NUM_W'(base)
        + $signed({NUM_W'(0) | {tol_i, 1'b0}});
    work_d.cmd  = cmd_i;
    work_d.base = base;
    work_d.num  = num;
    mag_d = num[NUM_W-1] ? MAG_W'(-num) : MAG_W'(num);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q <= work_d;
    mag_q  <= mag_d;
  end

  assign valid_o = valid_q;
  assign work_o  = work_q;
  assign mag_o   = mag_q;

endmodule

`default_nettype wire

// ===== design/bsau_div_stage.sv =====
`default_nettype none

module bsau_div_stage (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     valid_i,
  input  wire bsau_pkg::bsau_work_t     work_i,
  input  wire logic [bsau_pkg::MAG_W-1:0] mag_i,
  input  wire logic [bsau_pkg::REM_W-1:0] rem_i,
  input  wire logic [bsau_pkg::REM_W-1:0] div_i,
  output logic                          valid_o,
  output bsau_pkg::bsau_work_t          work_o,
  output logic [bsau_pkg::MAG_W-1:0]    mag_o,
  output logic [bsau_pkg::REM_W-1:0]    rem_o
);
  import bsau_pkg::*;

  logic                 valid_q;
  bsau_work_t           work_q;
  logic [MAG_W-1:0]     mag_d, mag_q;
  logic [REM_W-1:0]     rem_d, rem_q;
  logic [REM_W:0]       trial;
  logic [REM_W+1:0]     diff;

  // One restoring step: bring in the next dividend bit, subtract if it fits.
  always_comb begin
    trial = {rem_i, mag_i[MAG_W-1]};
    diff  = {1'b0, trial} - {2'b0, div_i};
    rem_d = diff[REM_W+1] ? trial[REM_W-1:0] : diff[REM_W-1:0];
    mag_d = {mag_i[MAG_W-2:0], 1'b0};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q <= work_i;
    mag_q  <= mag_d;
    rem_q  <= rem_d;
  end

  assign valid_o = valid_q;
  assign work_o  = work_q;
  assign mag_o   = mag_q;
  assign rem_o   = rem_q;

endmodule

`default_nettype wire

// ===== design/bsau_post.sv =====
`default_nettype none

module bsau_post #(
  parameter int unsigned GRID_SIDE = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     valid_i,
  input  wire bsau_pkg::bsau_work_t     work_i,
  input  wire logic [bsau_pkg::REM_W-1:0] rem_i,
  input  wire logic [bsau_pkg::REM_W-1:0] div_i,
  input  wire logic [15:0]              tol_i,
  output logic                          valid_o,
  output bsau_pkg::bsau_res_t           res_o
);
  import bsau_pkg::*;

  localparam logic [31:0] GRID_MAX = 32'(GRID_SIDE - 1);

  // Stage one: exact floor multiple and target remainder.
  logic                 v1_q;
  bsau_work_t           w1_q;
  logic signed [31:0]   h_d, h_q, hc_d, hc_q;
  logic [REM_W-1:0]     rfix;
  logic signed [35:0]   lowered;

  always_comb begin
    rfix = (work_i.num[NUM_W-1] && (rem_i != '0)) ? (div_i - rem_i) : rem_i;
    lowered = 36'(work_i.num) - $signed({4'b0, rfix});
    h_d  = sat32(lowered >>> 1);
    hc_d = sat32(36'(work_i.cmd.src_soil_top) + 36'(work_i.base) - 36'(h_d));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    w1_q <= work_i;
    h_q  <= h_d;
    hc_q <= hc_d;
  end

  // Stage two: case decision and result assembly.
  logic               v2_q;
  bsau_res_t          res_d, res_q;
  logic signed [35:0] bb, tt, base, b1b, b2b, tol, hx, hcx, fbase;
  logic [3:0]         op;
  logic               partial, empty, low2, hc_b1, hc_b2;
  logic [1:0]         slot;
  logic signed [31:0] slot_val;

  always_comb begin
    op   = w1_q.cmd.operation;
    bb   = 36'(w1_q.cmd.src_soil_bottom);
    tt   = 36'(w1_q.cmd.src_soil_top);
    base = 36'(w1_q.base);
    b1b  = 36'(w1_q.cmd.tgt_bucket1_bottom);
    b2b  = 36'(w1_q.cmd.tgt_bucket2_bottom);
    tol  = $signed({20'b0, tol_i});
    hx   = 36'(h_q);
    hcx  = 36'(hc_q);
    low2 = b1b > b2b;
    hc_b1 = (hcx - tol) > b1b;
    hc_b2 = (hcx - tol) > b2b;
    if (op == OP_S2O_SOIL || op == OP_S2O_BUCKET) begin
      partial = (hcx - tol) > bb;
    end else begin
      partial = (hx - tol) > bb;
    end
    empty = 1'b0;
    fbase = base;
    slot  = 2'd3;
    slot_val = '0;

    res_d.new_src_bottom   = w1_q.cmd.src_soil_bottom;
    res_d.new_src_top      = w1_q.cmd.src_soil_top;
    res_d.new_terrain      = w1_q.cmd.tgt_terrain;
    res_d.new_soil1_bottom = (w1_q.cmd.tgt_soil1_top != '0) ? w1_q.cmd.tgt_bucket1_top : '0;
    res_d.new_soil1_top    = w1_q.cmd.tgt_soil1_top;
    res_d.new_soil2_bottom = (w1_q.cmd.tgt_soil2_top != '0) ? w1_q.cmd.tgt_bucket2_top : '0;
    res_d.new_soil2_top    = w1_q.cmd.tgt_soil2_top;
    res_d.created_valid    = 1'b0;
    res_d.created_layer    = LAYER_FIRST;
    res_d.created_row      = '0;
    res_d.created_col      = '0;

    if (op <= OP_B1_BUCKET) begin
      if (op == OP_S1_BUCKET || op == OP_B1_BUCKET) begin
        res_d.created_valid    = 1'b1;
        res_d.created_layer    = LAYER_FIRST;
        res_d.new_soil1_bottom = w1_q.cmd.tgt_bucket1_top;
      end
      if (op == OP_S2O_BUCKET || op == OP_S2_BUCKET) begin
        res_d.created_valid    = 1'b1;
        res_d.created_layer    = LAYER_SECOND;
        res_d.new_soil2_bottom = w1_q.cmd.tgt_bucket2_top;
      end

      if (op == OP_S2_SOIL && low2 && partial && hc_b1) begin
        res_d.new_src_top   = sat32(tt - (b1b - 36'(w1_q.cmd.tgt_soil2_top)));
        res_d.new_soil2_top = w1_q.cmd.tgt_bucket1_bottom;
      end else if (op == OP_S2_BUCKET && low2 && partial && hc_b1) begin
        res_d.new_src_top   = sat32(tt - (b1b - 36'(w1_q.cmd.tgt_bucket2_top)));
        res_d.new_soil2_top = w1_q.cmd.tgt_bucket1_bottom;
      end else if ((op == OP_B1_SOIL || op == OP_B1_BUCKET) && !low2 && partial
                   && hc_b2) begin
        res_d.new_src_top   = sat32(tt - (b2b - base));
        res_d.new_soil1_top = w1_q.cmd.tgt_bucket2_bottom;
      end else begin
        if (op == OP_TERRAIN) begin
          slot = 2'd0;
        end else if (op == OP_S1_SOIL || op == OP_S1_BUCKET || op == OP_B1_SOIL
                     || op == OP_B1_BUCKET) begin
          slot = 2'd1;
        end else begin
          slot = 2'd2;
        end
        if (op == OP_S2_BUCKET && low2) begin
          if (partial) begin
            res_d.new_soil2_bottom = w1_q.cmd.tgt_bucket2_bottom;
          end else begin
            fbase = b2b;
          end
        end
        if (partial) begin
          slot_val          = hc_q;
          res_d.new_src_top = h_q;
        end else begin
          slot_val = sat32(fbase + tt - bb);
          empty    = 1'b1;
        end
      end

      case (slot)
        2'd0:    res_d.new_terrain   = slot_val;
        2'd1:    res_d.new_soil1_top = slot_val;
        2'd2:    res_d.new_soil2_top = slot_val;
        default: ;
      endcase

      if (empty) begin
        res_d.new_src_bottom = '0;
        res_d.new_src_top    = '0;
      end
    end

    if (res_d.created_valid) begin
      res_d.created_row = ({22'b0, w1_q.cmd.target_row} >= GRID_SIDE) ?
                          GRID_MAX[9:0] : w1_q.cmd.target_row;
      res_d.created_col = ({22'b0, w1_q.cmd.target_col} >= GRID_SIDE) ?
                          GRID_MAX[9:0] : w1_q.cmd.target_col;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign valid_o = v2_q;
  assign res_o   = res_q;

endmodule

`default_nettype wire

// ===== design/body_soil_avalanche_update.sv =====
// Channel     | Direction | Handshake                    | Payload
// command     | in        | start, busy (accept: start & !busy) | cmd_i
// result      | out       | done_o strobe, one cycle     | result_o
// config      | in        | cfg_valid_i, cfg_ready_o     | cfg_index_i, cfg_data_i
//
// A command is taken in every cycle; it passes through the prep register, the
// remainder pipeline (one dividend bit per stage) and the post stages.
// Reset clears all valid bits; no command is in flight afterward.
// The receiver cannot stall, so busy stays low and the pipeline never stops.
`default_nettype none

module body_soil_avalanche_update #(
  parameter int unsigned GRID_SIDE = 1024
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start,
  output logic                      busy,
  input  wire bsau_pkg::bsau_cmd_t  cmd_i,
  output logic                      done_o,
  output bsau_pkg::bsau_res_t       result_o,
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [1:0]           cfg_index_i,
  input  wire logic [31:0]          cfg_data_i
);
  import bsau_pkg::*;

  logic [30:0]      dh_q;
  logic [15:0]      tol_q;
  logic [30:0]      cell_q;
  logic [REM_W-1:0] divisor;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dh_q   <= 31'd65536;
      tol_q  <= 16'd1;
      cell_q <= 31'd65536;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_DH:   dh_q   <= cfg_data_i[30:0];
        CFG_TOL:  tol_q  <= cfg_data_i[15:0];
        CFG_CELL: cell_q <= cfg_data_i[30:0];
        default:  ;
      endcase
    end
  end

  assign divisor = {((cell_q == '0) ? 31'd1 : cell_q), 1'b0};

  logic                 sv   [DIV_STAGES+1];
  bsau_work_t           sw   [DIV_STAGES+1];
  logic [MAG_W-1:0]     smag [DIV_STAGES+1];
  logic [REM_W-1:0]     srem [DIV_STAGES+1];

  bsau_prep u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start && !busy),
    .cmd_i   (cmd_i),
    .dh_i    (dh_q),
    .tol_i   (tol_q),
    .valid_o (sv[0]),
    .work_o  (sw[0]),
    .mag_o   (smag[0])
  );
  assign srem[0] = '0;

  for (genvar i = 0; i < DIV_STAGES; i++) begin : g_div
    bsau_div_stage u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (sv[i]),
      .work_i  (sw[i]),
      .mag_i   (smag[i]),
      .rem_i   (srem[i]),
      .div_i   (divisor),
      .valid_o (sv[i+1]),
      .work_o  (sw[i+1]),
      .mag_o   (smag[i+1]),
      .rem_o   (srem[i+1])
    );
  end

  bsau_post #(
    .GRID_SIDE (GRID_SIDE)
  ) u_post (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (sv[DIV_STAGES]),
    .work_i  (sw[DIV_STAGES]),
    .rem_i   (srem[DIV_STAGES]),
    .div_i   (divisor),
    .tol_i   (tol_q),
    .valid_o (done_o),
    .res_o   (result_o)
  );

endmodule

`default_nettype wire

// ===== design/bsau_checker.sv =====
`default_nettype none

module bsau_checker #(
  parameter int unsigned GRID_SIDE = 1024
) (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                done_o,
  input wire bsau_pkg::bsau_res_t result_o
);
  import bsau_pkg::*;

`include "body_soil_avalanche_update_assert.svh"

  `BSAU_ASSERT_IMP(a_layer_code, done_o && result_o.created_valid, result_o.created_layer == LAYER_FIRST || result_o.created_layer == LAYER_SECOND, "Created layer code out of range.")
  `BSAU_ASSERT_IMP(a_no_create_zero, done_o && !result_o.created_valid, result_o.created_layer == 2'd0 && result_o.created_row == 10'd0 && result_o.created_col == 10'd0, "Position fields set without a created layer.")
  `BSAU_ASSERT_IMP(a_pos_in_grid, done_o && result_o.created_valid, ({22'b0, result_o.created_row} < GRID_SIDE) && ({22'b0, result_o.created_col} < GRID_SIDE), "Created position outside the grid.")

endmodule

bind body_soil_avalanche_update bsau_checker #(
  .GRID_SIDE (GRID_SIDE)
) u_bsau_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .done_o   (done_o),
  .result_o (result_o)
);

`default_nettype wire
